[rtl/core/uart_register_datagram_engine_top_defines.svh]
// ----------------------------------------------------------------------------
// uart register datagram engine assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef UART_REGISTER_DATAGRAM_ENGINE_TOP_DEFINES_SVH
`define UART_REGISTER_DATAGRAM_ENGINE_TOP_DEFINES_SVH

// condition that holds at every clock edge outside reset
`define UDG_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// condition that implies another one at the following edge
`define UDG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/udg_pkg.sv]
// ----------------------------------------------------------------------------
// udg_pkg
// shared types, codes and crc helper of the uart register datagram engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package udg_pkg;

  // input item kinds
  typedef enum logic [1:0] {
    REQ_WRITE  = 2'd0,
    REQ_READ   = 2'd1,
    REQ_RXBYTE = 2'd2,
    REQ_TICK   = 2'd3
  } req_t;

  // result item kinds
  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_OK   = 2'd1,
    KIND_FAIL = 2'd2
  } kind_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SYNC   = 2'd0,
    CFG_NODE   = 2'd1,
    CFG_RETRY  = 2'd2,
    CFG_WINDOW = 2'd3
  } cfg_idx_t;

  // front-end phase
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_HUNT    = 2'd1,
    PH_COLLECT = 2'd2,
    PH_CHECK   = 2'd3
  } phase_t;

  // back-end sequencer state
  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_RUN  = 1'b1
  } bk_state_t;

  // jobs handed from front to back
  typedef enum logic [1:0] {
    JOB_WRITE = 2'd0,
    JOB_READ  = 2'd1,
    JOB_OK    = 2'd2,
    JOB_FAIL  = 2'd3
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [7:0]  sync;
    logic [1:0]  node;
    logic [7:0]  addr_byte;
    logic [31:0] data;
  } job_t;

  // live configuration
  typedef struct packed {
    logic [7:0]  sync;
    logic [1:0]  node;
    logic [3:0]  retry;
    logic [15:0] window;
  } cfg_t;

  localparam logic [7:0]  CRC_POLY     = 8'h07;
  localparam logic [7:0]  PATTERN_MID  = 8'hFF;
  localparam logic [7:0]  WRITE_FLAG   = 8'h80;
  localparam int          REPLY_BYTES  = 5;
  localparam int          CHECK_BYTES  = 7;
  localparam int          WRITE_LEN    = 8;
  localparam int          READ_LEN     = 4;
  localparam int          QUEUE_DEPTH  = 4;

  localparam logic [7:0]  SYNC_RST     = 8'd5;
  localparam logic [1:0]  NODE_RST     = 2'd0;
  localparam logic [3:0]  RETRY_RST    = 4'd2;
  localparam logic [15:0] WINDOW_RST   = 16'd5;

  // crc-8 over one byte, bits taken lsb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] din);
    logic [7:0] c;
    logic       fb;
    c = crc_in;
    for (int j = 0; j < 8; j++) begin
      fb = c[7] ^ din[j];
      c  = {c[6:0], 1'b0};
      if (fb) begin
        c = c ^ CRC_POLY;
      end
    end
    return c;
  endfunction

endpackage

[rtl/core/udg_queue.sv]
// ----------------------------------------------------------------------------
// udg_queue
// small job queue between the front and back of the datagram engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "uart_register_datagram_engine_top_defines.svh"

module udg_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `UDG_ASSERT(a_no_overflow, !(push && full && !pop), "job pushed into a full queue")
  `UDG_ASSERT(a_no_underflow, !(pop && empty), "job popped from an empty queue")

endmodule

[rtl/core/udg_front.sv]
// ----------------------------------------------------------------------------
// udg_front
// accepts input items, tracks the read transaction and queues jobs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "uart_register_datagram_engine_top_defines.svh"

module udg_front (
  input  logic          clk,
  input  logic          rst_n,
  input  udg_pkg::cfg_t cfg,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [1:0]    in_tuser,
  input  logic [47:0]   in_tdata,
  output logic          push,
  output udg_pkg::job_t push_job,
  input  logic          q_full
);

  udg_pkg::phase_t phase_r, phase_nxt;
  logic [23:0] sw_r, sw_nxt;
  logic [39:0] cap_r, cap_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [3:0]  att_r, att_nxt;
  logic [6:0]  pend_r, pend_nxt;
  logic [2:0]  step_r, step_nxt;
  logic [7:0]  crc_r, crc_nxt;

  udg_pkg::req_t req;
  logic [6:0]  reg_addr;
  logic [31:0] wdata;
  logic [7:0]  rx;
  logic        acc;
  logic        active;
  logic        retry_more;
  logic        tick_over;
  logic        hunt_hit;
  logic        collect_done;
  logic        chk_last;
  logic        crc_good;
  logic [7:0]  chk_byte;
  logic        restart;
  logic        fail_out;

  // field unpacking
  assign req      = udg_pkg::req_t'(in_tuser);
  assign reg_addr = in_tdata[6:0];
  assign wdata    = in_tdata[38:7];
  assign rx       = in_tdata[46:39];

  // shared decisions
  assign in_tready    = (phase_r != udg_pkg::PH_CHECK) && !q_full;
  assign acc          = in_tvalid && in_tready;
  assign active       = (phase_r == udg_pkg::PH_HUNT) || (phase_r == udg_pkg::PH_COLLECT);
  assign retry_more   = (att_r < cfg.retry);
  assign tick_over    = ({1'b0, tick_r} + 17'd1) > {1'b0, cfg.window};
  assign hunt_hit     = ({sw_r[15:0], rx} == {cfg.sync, udg_pkg::PATTERN_MID, 1'b0, pend_r});
  assign collect_done = (cnt_r == 3'(udg_pkg::REPLY_BYTES - 1));
  assign chk_last     = (step_r == 3'(udg_pkg::CHECK_BYTES));
  assign crc_good     = (crc_r == cap_r[7:0]) && (crc_r != 8'd0);

  // reply byte fed to the crc check, one per cycle
  always_comb begin
    case (step_r)
      3'd0:    chk_byte = cfg.sync;
      3'd1:    chk_byte = udg_pkg::PATTERN_MID;
      3'd2:    chk_byte = {1'b0, pend_r};
      3'd3:    chk_byte = cap_r[39:32];
      3'd4:    chk_byte = cap_r[31:24];
      3'd5:    chk_byte = cap_r[23:16];
      3'd6:    chk_byte = cap_r[15:8];
      default: chk_byte = 8'd0;
    endcase
  end

  // phase next state
  always_comb begin
    phase_nxt = phase_r;
    if (acc) begin
      unique case (req)
        udg_pkg::REQ_WRITE: phase_nxt = phase_r;
        udg_pkg::REQ_READ: begin
          phase_nxt = (cfg.retry == 4'd0) ? udg_pkg::PH_IDLE : udg_pkg::PH_HUNT;
        end
        udg_pkg::REQ_RXBYTE: begin
          if (phase_r == udg_pkg::PH_HUNT && hunt_hit) begin
            phase_nxt = udg_pkg::PH_COLLECT;
          end else if (phase_r == udg_pkg::PH_COLLECT && collect_done) begin
            phase_nxt = udg_pkg::PH_CHECK;
          end
        end
        udg_pkg::REQ_TICK: begin
          if (active && tick_over) begin
            phase_nxt = retry_more ? udg_pkg::PH_HUNT : udg_pkg::PH_IDLE;
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end else if (phase_r == udg_pkg::PH_CHECK && chk_last && !q_full) begin
      phase_nxt = (!crc_good && retry_more) ? udg_pkg::PH_HUNT : udg_pkg::PH_IDLE;
    end
  end

  // datapath and job output
  always_comb begin
    push     = 1'b0;
    push_job = '0;
    sw_nxt   = sw_r;
    cap_nxt  = cap_r;
    cnt_nxt  = cnt_r;
    tick_nxt = tick_r;
    att_nxt  = att_r;
    pend_nxt = pend_r;
    step_nxt = step_r;
    crc_nxt  = crc_r;
    restart  = 1'b0;
    fail_out = 1'b0;
    if (acc) begin
      unique case (req)
        udg_pkg::REQ_WRITE: begin
          push               = 1'b1;
          push_job.kind      = udg_pkg::JOB_WRITE;
          push_job.sync      = cfg.sync;
          push_job.node      = cfg.node;
          push_job.addr_byte = udg_pkg::WRITE_FLAG | {1'b0, reg_addr};
          push_job.data      = wdata;
        end
        udg_pkg::REQ_READ: begin
          pend_nxt = reg_addr;
          att_nxt  = '0;
          if (cfg.retry == 4'd0) begin
            fail_out = 1'b1;
          end else begin
            restart = 1'b1;
          end
        end
        udg_pkg::REQ_TICK: begin
          if (active) begin
            if (tick_over) begin
              if (retry_more) begin
                restart = 1'b1;
              end else begin
                fail_out = 1'b1;
              end
            end else begin
              tick_nxt = tick_r + 16'd1;
            end
          end
        end
        udg_pkg::REQ_RXBYTE: begin
          if (phase_r == udg_pkg::PH_HUNT) begin
            sw_nxt = {sw_r[15:0], rx};
            if (hunt_hit) begin
              cap_nxt  = '0;
              cnt_nxt  = '0;
              tick_nxt = '0;
            end
          end else if (phase_r == udg_pkg::PH_COLLECT) begin
            cap_nxt = {cap_r[31:0], rx};
            cnt_nxt = cnt_r + 3'd1;
            if (collect_done) begin
              cnt_nxt  = '0;
              step_nxt = '0;
              crc_nxt  = '0;
            end
          end
        end
        default: push = 1'b0;
      endcase
    end else if (phase_r == udg_pkg::PH_CHECK) begin
      if (!chk_last) begin
        crc_nxt  = udg_pkg::crc8_byte(crc_r, chk_byte);
        step_nxt = step_r + 3'd1;
      end else if (!q_full) begin
        if (crc_good) begin
          push          = 1'b1;
          push_job.kind = udg_pkg::JOB_OK;
          push_job.data = cap_r[39:8];
        end else if (retry_more) begin
          restart = 1'b1;
        end else begin
          fail_out = 1'b1;
        end
      end
    end
    // (re)send of the read request
    if (restart) begin
      push               = 1'b1;
      push_job.kind      = udg_pkg::JOB_READ;
      push_job.sync      = cfg.sync;
      push_job.node      = cfg.node;
      push_job.addr_byte = {1'b0, pend_nxt};
      push_job.data      = '0;
      sw_nxt             = '0;
      cap_nxt            = '0;
      cnt_nxt            = '0;
      tick_nxt           = '0;
      att_nxt            = att_nxt + 4'd1;
    end
    // read given up
    if (fail_out) begin
      push          = 1'b1;
      push_job      = '0;
      push_job.kind = udg_pkg::JOB_FAIL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= udg_pkg::PH_IDLE;
      sw_r    <= '0;
      cap_r   <= '0;
      cnt_r   <= '0;
      tick_r  <= '0;
      att_r   <= '0;
      pend_r  <= '0;
      step_r  <= '0;
      crc_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      sw_r    <= sw_nxt;
      cap_r   <= cap_nxt;
      cnt_r   <= cnt_nxt;
      tick_r  <= tick_nxt;
      att_r   <= att_nxt;
      pend_r  <= pend_nxt;
      step_r  <= step_nxt;
      crc_r   <= crc_nxt;
    end
  end

  `UDG_ASSERT_NEXT(a_read_hunts, acc && req == udg_pkg::REQ_READ && cfg.retry != 4'd0, phase_r == udg_pkg::PH_HUNT && att_r == 4'd1, "read request did not start a hunt")
  `UDG_ASSERT(a_ok_from_check, !(push && push_job.kind == udg_pkg::JOB_OK) || (phase_r == udg_pkg::PH_CHECK && chk_last), "read ok queued outside the crc check")

endmodule

[rtl/core/udg_back.sv]
// ----------------------------------------------------------------------------
// udg_back
// expands queued jobs into result items, one item per cycle while the receiver is ready, with crc
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "uart_register_datagram_engine_top_defines.svh"

module udg_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_empty,
  input  udg_pkg::job_t q_data,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [1:0]    out_tuser,
  output logic [39:0]   out_tdata,
  output logic          out_tlast
);

  udg_pkg::bk_state_t st_r, st_nxt;
  udg_pkg::job_t      job_r;
  logic [2:0]         idx_r;
  logic [7:0]         crc_r;
  logic               out_valid_r;
  udg_pkg::kind_t     out_kind_r;
  logic [7:0]         out_byte_r;
  logic               out_last_r;
  logic [31:0]        out_data_r;

  logic               out_adv;
  logic               emit;
  logic               is_final;
  logic [2:0]         last_idx;
  udg_pkg::kind_t     kind_sel;
  logic [7:0]         byte_sel;
  logic               last_sel;
  logic [31:0]        data_sel;

  assign out_adv = !out_valid_r || out_tready;

  // final item index of the current job
  always_comb begin
    case (job_r.kind)
      udg_pkg::JOB_WRITE: last_idx = 3'(udg_pkg::WRITE_LEN - 1);
      udg_pkg::JOB_READ:  last_idx = 3'(udg_pkg::READ_LEN - 1);
      default:            last_idx = 3'd0;
    endcase
  end
  assign is_final = (idx_r == last_idx);

  // sequencer next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      udg_pkg::BK_IDLE: if (!q_empty) st_nxt = udg_pkg::BK_RUN;
      udg_pkg::BK_RUN:  if (out_adv && is_final) st_nxt = udg_pkg::BK_IDLE;
      default:          st_nxt = udg_pkg::BK_IDLE;
    endcase
  end

  // sequencer outputs and item select
  always_comb begin
    pop      = (st_r == udg_pkg::BK_IDLE) && !q_empty;
    emit     = (st_r == udg_pkg::BK_RUN) && out_adv;
    kind_sel = udg_pkg::KIND_TX;
    byte_sel = 8'd0;
    last_sel = 1'b0;
    data_sel = '0;
    unique case (job_r.kind)
      udg_pkg::JOB_WRITE, udg_pkg::JOB_READ: begin
        last_sel = is_final;
        if (is_final) begin
          byte_sel = crc_r;
        end else begin
          case (idx_r)
            3'd0:    byte_sel = job_r.sync;
            3'd1:    byte_sel = {6'd0, job_r.node};
            3'd2:    byte_sel = job_r.addr_byte;
            3'd3:    byte_sel = job_r.data[31:24];
            3'd4:    byte_sel = job_r.data[23:16];
            3'd5:    byte_sel = job_r.data[15:8];
            3'd6:    byte_sel = job_r.data[7:0];
            default: byte_sel = crc_r;
          endcase
        end
      end
      udg_pkg::JOB_OK: begin
        kind_sel = udg_pkg::KIND_OK;
        data_sel = job_r.data;
      end
      udg_pkg::JOB_FAIL: kind_sel = udg_pkg::KIND_FAIL;
      default:           kind_sel = udg_pkg::KIND_TX;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= udg_pkg::BK_IDLE;
      idx_r <= '0;
      crc_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (pop) begin
        idx_r <= '0;
        crc_r <= '0;
      end else if (emit) begin
        idx_r <= idx_r + 3'd1;
        crc_r <= udg_pkg::crc8_byte(crc_r, byte_sel);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= q_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= kind_sel;
      out_byte_r <= byte_sel;
      out_last_r <= last_sel;
      out_data_r <= data_sel;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_data_r, out_byte_r};
  assign out_tlast  = out_last_r;

  `UDG_ASSERT(a_pop_only_idle, !pop || (st_r == udg_pkg::BK_IDLE && !emit), "job loaded while a job is running")

endmodule

[rtl/core/uart_register_datagram_engine_top.sv]
// ----------------------------------------------------------------------------
// uart_register_datagram_engine_top
// register write/read datagram engine for a single-wire uart driver link
// ----------------------------------------------------------------------------
// The front takes one input item per cycle while the job queue has room and
// no reply crc check runs; a write request is turned into 8 transmit items
// and a read request into 4, emitted by the back at one item per cycle while
// the receiver is ready, each job first loaded from the QUEUE_DEPTH-entry queue,
// with the crc-8 built as the bytes go out. On the last reply byte the front
// runs the reply crc one byte per cycle over 7 bytes and then decides once the
// job queue has room, and the input stalls while it does so.
`timescale 1ns / 1ps

module uart_register_datagram_engine_top #(
  parameter int QUEUE_DEPTH = udg_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // reg_addr[6:0], write_data[38:7], rx_byte[46:39], 0
  input  logic [1:0]  in_tuser,   // req_type[1:0]
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // tx_byte[7:0], read_data[39:8]
  output logic [1:0]  out_tuser,  // out_kind[1:0]
  output logic        out_tlast,  // last_byte
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  udg_pkg::cfg_t cfg_r;
  udg_pkg::job_t push_job;
  udg_pkg::job_t q_data;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync   <= udg_pkg::SYNC_RST;
      cfg_r.node   <= udg_pkg::NODE_RST;
      cfg_r.retry  <= udg_pkg::RETRY_RST;
      cfg_r.window <= udg_pkg::WINDOW_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (udg_pkg::cfg_idx_t'(cfg_index))
        udg_pkg::CFG_SYNC:   cfg_r.sync   <= cfg_data[7:0];
        udg_pkg::CFG_NODE:   cfg_r.node   <= cfg_data[1:0];
        udg_pkg::CFG_RETRY:  cfg_r.retry  <= cfg_data[3:0];
        udg_pkg::CFG_WINDOW: cfg_r.window <= cfg_data;
        default:             cfg_r.sync   <= cfg_r.sync;
      endcase
    end
  end

  // front: accept and classify
  udg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full)
  );

  // job queue
  udg_queue #(
    .WIDTH ($bits(udg_pkg::job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_job),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  // back: emit result items
  udg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (q_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

[tb/uart_register_datagram_engine_top_tb.sv]
// ----------------------------------------------------------------------------
// uart_register_datagram_engine_top_tb
// Self-checking bench for the uart register datagram engine. Request,
// reply-byte and tick items are streamed in with random bursts and gaps.
// A cycle-free predictor of the framing, reply hunting, crc check and retry
// logic computes the result items owed, and each result item taken from the
// block is compared field by field against the oldest one. The run steps
// through several register settings, extremes included, and the receiver
// stalls on patterns of its own, with one long hold-off that backs up the
// block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uart_register_datagram_engine_top_tb;

  localparam logic [7:0] POLY = 8'h07;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD_CYCLES = 300;

  // one input item as the block sees it
  typedef struct {
    udg_pkg::req_t req;
    logic [6:0]    addr;
    logic [31:0]   wdata;
    logic [7:0]    rx;
  } link_item_t;

  // one result item owed by the block
  typedef struct {
    udg_pkg::kind_t kind;
    logic [7:0]     txb;
    logic           last;
    logic [31:0]    rdata;
  } link_result_t;

  typedef enum int {RP_GOOD, RP_BAD_CRC, RP_ZERO_CRC, RP_SHORT} reply_t;
  typedef enum int {RM_OPEN, RM_COIN, RM_SPARSE, RM_PATTERN} ready_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [1:0]  in_tuser = udg_pkg::REQ_WRITE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = udg_pkg::CFG_SYNC;
  logic [15:0] cfg_data = '0;

  // item feed, owed results and bookkeeping
  link_item_t   feed_q[$];
  link_result_t owed_q[$];
  int n_queued = 0;
  int n_taken = 0;
  int n_checked = 0;
  int errors = 0;

  // live register copy
  logic [7:0]  sync_r = udg_pkg::SYNC_RST;
  logic [1:0]  node_r = udg_pkg::NODE_RST;
  logic [3:0]  retry_r = udg_pkg::RETRY_RST;
  logic [15:0] window_r = udg_pkg::WINDOW_RST;

  // predicted link state
  udg_pkg::phase_t ph = udg_pkg::PH_IDLE;
  logic [23:0] hunt_win = '0;
  logic [39:0] cap_sr = '0;
  logic [2:0]  cap_cnt = '0;
  logic [15:0] tick_cnt = '0;
  logic [3:0]  tries = '0;
  logic [6:0]  rd_addr = '0;

  always #1 clk = ~clk;

  uart_register_datagram_engine_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // crc-8, poly 0x07, bits of each byte lsb first, start value zero
  function automatic logic [7:0] crc8_of(input logic [7:0] b [8], input int n);
    logic [7:0] c;
    logic       fb;
    int         i;
    int         j;
    c = 8'h00;
    for (i = 0; i < n; i++) begin
      for (j = 0; j < 8; j++) begin
        fb = c[7] ^ b[i][j];
        c  = {c[6:0], 1'b0} ^ (fb ? POLY : 8'h00);
      end
    end
    return c;
  endfunction

  function automatic void owe(input udg_pkg::kind_t k, input logic [7:0] b, input logic l,
                              input logic [31:0] d);
    link_result_t r;
    r.kind  = k;
    r.txb   = b;
    r.last  = l;
    r.rdata = d;
    owed_q.push_back(r);
  endfunction

  // read datagram goes out and the hunt starts over
  function automatic void issue_read();
    logic [7:0] d [8];
    int         i;
    d = '{default: 8'h00};
    d[0] = sync_r;
    d[1] = {6'd0, node_r};
    d[2] = {1'b0, rd_addr};
    d[3] = crc8_of(d, 3);
    for (i = 0; i < udg_pkg::READ_LEN; i++) begin
      owe(udg_pkg::KIND_TX, d[i], i == udg_pkg::READ_LEN - 1, 32'd0);
    end
    ph       = udg_pkg::PH_HUNT;
    hunt_win = '0;
    cap_sr   = '0;
    cap_cnt  = '0;
    tick_cnt = '0;
    tries    = tries + 4'd1;
  endfunction

  function automatic void read_attempt_lost();
    if (tries < retry_r) begin
      issue_read();
    end else begin
      ph = udg_pkg::PH_IDLE;
      owe(udg_pkg::KIND_FAIL, 8'h00, 1'b0, 32'd0);
    end
  endfunction

  // advance the predicted link by one accepted item
  function automatic void link_step(input link_item_t it);
    logic [7:0]  d [8];
    logic [31:0] data;
    int          i;
    d = '{default: 8'h00};
    case (it.req)
      udg_pkg::REQ_WRITE: begin
        d[0] = sync_r;
        d[1] = {6'd0, node_r};
        d[2] = udg_pkg::WRITE_FLAG | {1'b0, it.addr};
        d[3] = it.wdata[31:24];
        d[4] = it.wdata[23:16];
        d[5] = it.wdata[15:8];
        d[6] = it.wdata[7:0];
        d[7] = crc8_of(d, 7);
        for (i = 0; i < udg_pkg::WRITE_LEN; i++) begin
          owe(udg_pkg::KIND_TX, d[i], i == udg_pkg::WRITE_LEN - 1, 32'd0);
        end
      end
      udg_pkg::REQ_READ: begin
        rd_addr = it.addr;
        tries   = '0;
        if (retry_r == 4'd0) begin
          ph = udg_pkg::PH_IDLE;
          owe(udg_pkg::KIND_FAIL, 8'h00, 1'b0, 32'd0);
        end else begin
          issue_read();
        end
      end
      default: begin
        if (ph != udg_pkg::PH_HUNT && ph != udg_pkg::PH_COLLECT) begin
          // traffic while idle is dropped
          ph = udg_pkg::PH_IDLE;
        end else if (it.req == udg_pkg::REQ_TICK) begin
          if ({1'b0, tick_cnt} + 17'd1 > {1'b0, window_r}) begin
            read_attempt_lost();
          end else begin
            tick_cnt = tick_cnt + 16'd1;
          end
        end else if (ph == udg_pkg::PH_HUNT) begin
          hunt_win = {hunt_win[15:0], it.rx};
          if (hunt_win == {sync_r, udg_pkg::PATTERN_MID, 1'b0, rd_addr}) begin
            ph       = udg_pkg::PH_COLLECT;
            cap_sr   = '0;
            cap_cnt  = '0;
            tick_cnt = '0;
          end
        end else begin
          cap_sr  = {cap_sr[31:0], it.rx};
          cap_cnt = cap_cnt + 3'd1;
          if (cap_cnt >= 3'(udg_pkg::REPLY_BYTES)) begin
            data = cap_sr[39:8];
            d[0] = sync_r;
            d[1] = udg_pkg::PATTERN_MID;
            d[2] = {1'b0, rd_addr};
            d[3] = data[31:24];
            d[4] = data[23:16];
            d[5] = data[15:8];
            d[6] = data[7:0];
            d[7] = crc8_of(d, 7);
            cap_cnt = '0;
            // a zero crc is never taken as good
            if (d[7] != cap_sr[7:0] || d[7] == 8'h00) begin
              read_attempt_lost();
            end else begin
              ph = udg_pkg::PH_IDLE;
              owe(udg_pkg::KIND_OK, 8'h00, 1'b0, data);
            end
          end
        end
      end
    endcase
  endfunction

  // sender: bursts of random length with random gaps
  link_item_t cur_item;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        link_step(cur_item);
        n_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (feed_q.size() > 0) begin
          cur_item = feed_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {1'b0, cur_item.rx, cur_item.wdata, cur_item.addr};
          in_tuser  <= cur_item.req;
          if (burst_left > 0) begin
            burst_left--;
          end
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1: gap_left = $urandom_range(1, 3);
              2: gap_left = $urandom_range(1, 8);
              default: gap_left = $urandom_range(10, 30);
            endcase
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each result item and stalls on its own pattern
  ready_mode_t rmode = RM_OPEN;
  int mode_left = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;
  logic [7:0] stall_pat = 8'b1011_0010;
  int rcyc = 0;
  link_result_t got;
  logic rdy;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rcyc++;
      if (out_tvalid && out_tready) begin
        n_checked++;
        if (owed_q.size() == 0) begin
          $error("unexpected result item: out_kind %0d tx_byte %02h read_data %08h",
                 out_tuser, out_tdata[7:0], out_tdata[39:8]);
          errors++;
        end else begin
          got = owed_q.pop_front();
          if (out_tuser !== got.kind) begin
            $error("out_kind: expected %0d, got %0d", got.kind, out_tuser);
            errors++;
          end
          if (out_tdata[7:0] !== got.txb) begin
            $error("tx_byte: expected %02h, got %02h", got.txb, out_tdata[7:0]);
            errors++;
          end
          if (out_tlast !== got.last) begin
            $error("last_byte: expected %0b, got %0b", got.last, out_tlast);
            errors++;
          end
          if (out_tdata[39:8] !== got.rdata) begin
            $error("read_data: expected %08h, got %08h", got.rdata, out_tdata[39:8]);
            errors++;
          end
        end
      end
      // one long hold-off while the sender still has items waiting
      if (!long_hold_done && n_checked >= 40 && n_queued != n_taken) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          rmode     = ready_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(10, 80);
        end else begin
          mode_left--;
        end
        case (rmode)
          RM_OPEN:   rdy = 1'b1;
          RM_COIN:   rdy = 1'($urandom_range(0, 1));
          RM_SPARSE: rdy = ($urandom_range(0, 3) == 0);
          default:   rdy = stall_pat[rcyc % 8];
        endcase
      end
      out_tready <= rdy;
    end
  end

  // stimulus helpers; fields an item does not use carry random values
  task automatic put_item(input udg_pkg::req_t r, input logic [6:0] a, input logic [31:0] w,
                          input logic [7:0] x);
    link_item_t it;
    it.req   = r;
    it.addr  = a;
    it.wdata = w;
    it.rx    = x;
    feed_q.push_back(it);
    n_queued++;
  endtask

  task automatic put_write(input logic [6:0] a, input logic [31:0] w);
    put_item(udg_pkg::REQ_WRITE, a, w, 8'($urandom));
  endtask

  task automatic put_read(input logic [6:0] a);
    put_item(udg_pkg::REQ_READ, a, $urandom, 8'($urandom));
  endtask

  task automatic put_rx(input logic [7:0] x);
    put_item(udg_pkg::REQ_RXBYTE, 7'($urandom), $urandom, x);
  endtask

  task automatic put_tick();
    put_item(udg_pkg::REQ_TICK, 7'($urandom), $urandom, 8'($urandom));
  endtask

  function automatic logic [6:0] pick_addr();
    case ($urandom_range(0, 5))
      0: return 7'd0;
      1: return 7'd127;
      default: return 7'($urandom);
    endcase
  endfunction

  // reply stream: pattern, four data bytes msb first, crc
  task automatic put_reply(input logic [6:0] a, input reply_t flavor);
    logic [7:0]  b [8];
    logic [31:0] data;
    int          n;
    int          k;
    b    = '{default: 8'h00};
    b[0] = sync_r;
    b[1] = udg_pkg::PATTERN_MID;
    b[2] = {1'b0, a};
    data = $urandom;
    for (k = 0; k < 4096; k++) begin
      b[3] = data[31:24];
      b[4] = data[23:16];
      b[5] = data[15:8];
      b[6] = data[7:0];
      b[7] = crc8_of(b, 7);
      if (flavor != RP_ZERO_CRC || b[7] == 8'h00) begin
        break;
      end
      data = $urandom;
    end
    if (flavor == RP_BAD_CRC) begin
      b[7] = b[7] ^ 8'($urandom_range(1, 255));
    end
    n = (flavor == RP_SHORT) ? int'($urandom_range(1, 6)) : 8;
    for (k = 0; k < n; k++) begin
      put_rx(b[k]);
    end
  endtask

  // random traffic, mostly read exchanges with a reply of some flavor
  task automatic run_traffic(input int n_items);
    int         start;
    int         sel;
    int         k;
    int         cap;
    logic [6:0] a;
    start = n_queued;
    while (n_queued - start < n_items) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        put_write(pick_addr(), $urandom);
      end else if (sel < 65) begin
        a = pick_addr();
        put_read(a);
        repeat ($urandom_range(1, 3)) begin
          repeat ($urandom_range(0, 2)) put_rx(8'($urandom));
          cap = (window_r > 4) ? 4 : int'(window_r) - 1;
          repeat ($urandom_range(0, cap)) put_tick();
          k = $urandom_range(0, 99);
          if (k < 55) begin
            put_reply(a, RP_GOOD);
          end else if (k < 67) begin
            put_reply(a, RP_BAD_CRC);
          end else if (k < 77) begin
            put_reply(a, RP_ZERO_CRC);
          end else if (k < 87 && window_r <= 40) begin
            repeat (int'(window_r) + 1) put_tick();
          end else if (k < 94) begin
            put_reply(a, RP_SHORT);
          end else begin
            put_write(pick_addr(), $urandom);
          end
        end
      end else if (sel < 78) begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1)) put_rx(8'($urandom));
          else put_tick();
        end
      end else if (sel < 88) begin
        // near miss on the pattern
        put_rx(sync_r);
        put_rx(udg_pkg::PATTERN_MID);
        put_rx(8'($urandom));
      end else begin
        put_reply(pick_addr(), RP_GOOD);
      end
    end
  endtask

  // wait until every item is taken and every owed result has come
  task automatic wait_drained();
    forever begin
      @(posedge clk);
      if (n_taken == n_queued && owed_q.size() == 0) begin
        break;
      end
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input udg_pkg::cfg_idx_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(posedge clk);
      if (cfg_ready) begin
        break;
      end
    end
    cfg_valid <= 1'b0;
    case (idx)
      udg_pkg::CFG_SYNC:   sync_r   = val[7:0];
      udg_pkg::CFG_NODE:   node_r   = val[1:0];
      udg_pkg::CFG_RETRY:  retry_r  = val[3:0];
      udg_pkg::CFG_WINDOW: window_r = val;
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [7:0] s, input logic [1:0] nd, input logic [3:0] r,
                         input logic [15:0] w);
    write_cfg(udg_pkg::CFG_SYNC, {8'h00, s});
    write_cfg(udg_pkg::CFG_NODE, {14'd0, nd});
    write_cfg(udg_pkg::CFG_RETRY, {12'd0, r});
    write_cfg(udg_pkg::CFG_WINDOW, w);
  endtask

  // run sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, idle traffic, timeout with resend, write and read
    // during a read, good reply
    put_write(7'd0, 32'h0000_0000);
    put_write(7'd127, 32'hFFFF_FFFF);
    put_rx(8'hFF);
    put_tick();
    put_read(7'd127);
    repeat (6) put_tick();
    put_write(7'h2A, 32'h5A5A_A5A5);
    put_reply(7'd127, RP_GOOD);
    put_read(7'd0);
    put_read(7'd1);
    run_traffic(45);
    wait_drained();

    // lowest sync, top node, single try, window of one
    set_all(8'h00, 2'd3, 4'd1, 16'd1);
    run_traffic(40);
    wait_drained();

    // highest sync, most tries, longest window
    set_all(8'hFF, 2'd1, 4'd15, 16'hFFFF);
    run_traffic(40);
    wait_drained();

    // retry limit of zero, possibly while a read is still hunting
    set_all(8'($urandom), 2'd2, 4'd0, 16'd3);
    put_read(pick_addr());
    run_traffic(25);
    wait_drained();

    set_all(8'($urandom), 2'($urandom), 4'($urandom_range(3, 8)),
            16'($urandom_range(2, 12)));
    run_traffic(55);
    wait_drained();

    if (errors == 0) begin
      $display("uart_register_datagram_engine_top_tb: clean");
    end else begin
      $display("uart_register_datagram_engine_top_tb: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #400000;
    $display("uart_register_datagram_engine_top_tb: errors");
    $finish;
  end

endmodule
